// ===== rtl/twl_pkg.sv =====
// package: shared widths, codes and the queue entry type of the waveshaper
package twl_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int ADDR_MAX_W      = 16;
	localparam int SAMPLE_W        = 24;
	localparam int INDEX_W         = 10;
	localparam int VALUE_W         = 16;
	localparam int FRAC_W          = 16;
	localparam int LENGTH_W        = 11;
	localparam int IN_DATA_W       = 56;
	localparam int CFG_ADDR_W      = 1;
	localparam int CFG_DATA_W      = 11;
	localparam int QUEUE_DEPTH     = 4;

	typedef enum logic {
		REQ_SHAPE = 1'b0,
		REQ_WRITE = 1'b1
	} req_type_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_TABLE_LENGTH = 1'b0,
		CFG_TABLE_READY  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		req_type_t               kind;
		logic                    wr_ok;
		logic [ADDR_MAX_W-1:0]   addr;
		logic [VALUE_W-1:0]      value;
		logic [FRAC_W-1:0]       frac;
	} q_entry_t;

endpackage

// ===== rtl/twl_ram.sv =====
// generic ram: one write port, one read port with registered read data
module twl_ram import twl_pkg::*; #(
	parameter int WIDTH = VALUE_W,
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/twl_front.sv =====
// front end: takes items, classifies them, computes table index and fraction
module twl_front import twl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_DATA_W-1:0] s_tdata,
	input  logic                 s_tuser,
	input  logic [LENGTH_W-1:0]  table_length,
	input  logic                 q_full,
	output logic                 q_push,
	output q_entry_t             q_entry
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = ((AW + 1) > LENGTH_W) ? (AW + 1) : LENGTH_W;
	localparam int CW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
	localparam int PW = FRAC_W + AW;

	logic [SAMPLE_W-1:0] sample;
	logic [INDEX_W-1:0]  tbl_index;
	logic [VALUE_W-1:0]  tbl_value;
	logic [FRAC_W-1:0]   phase;
	logic [NW-1:0]       len_ext;
	logic [NW-1:0]       n_eff;
	logic [AW-1:0]       span;
	logic [PW-1:0]       prod;
	req_type_t           kind;

	assign sample    = s_tdata[SAMPLE_W-1:0];
	assign tbl_index = s_tdata[SAMPLE_W+INDEX_W-1:SAMPLE_W];
	assign tbl_value = s_tdata[SAMPLE_W+INDEX_W+VALUE_W-1:SAMPLE_W+INDEX_W];
	assign kind      = req_type_t'(s_tuser);

	// (x + 1) / 2 mod 1: adding one flips bit 16, halving drops bit 0
	assign phase = {~sample[FRAC_W], sample[FRAC_W-1:1]};

	assign len_ext = NW'(table_length);

	always_comb begin
		if (len_ext < NW'(2)) begin
			n_eff = NW'(2);
		end else if (len_ext > NW'(TABLE_DEPTH)) begin
			n_eff = NW'(TABLE_DEPTH);
		end else begin
			n_eff = len_ext;
		end
	end

	assign span = AW'(n_eff - NW'(1));
	assign prod = PW'(phase) * PW'(span);

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_entry.kind  = kind;
		q_entry.wr_ok = CW'(tbl_index) < CW'(TABLE_DEPTH);
		q_entry.value = tbl_value;
		q_entry.frac  = prod[FRAC_W-1:0];
		unique case (kind)
			REQ_WRITE: q_entry.addr = ADDR_MAX_W'(tbl_index);
			REQ_SHAPE: q_entry.addr = ADDR_MAX_W'(prod[PW-1:FRAC_W]);
			default:   q_entry.addr = '0;
		endcase
	end

endmodule

// ===== rtl/twl_queue.sv =====
// short queue between front end and back end
module twl_queue import twl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     full,
	input  logic     pop,
	output q_entry_t dout,
	output logic     empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	q_entry_t         entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign dout  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/twl_back.sv =====
// back end: table writes, two-point lookup and linear interpolation
module twl_back import twl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  q_entry_t           q_entry,
	input  logic               q_empty,
	output logic               q_pop,
	input  logic               table_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata
);

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int PROD_W = VALUE_W + FRAC_W + 2;
	localparam int SUM_W  = VALUE_W + 2;

	logic                     advance;
	logic                     is_write;
	logic                     ram_we;
	logic                     ram_re;
	logic [AW-1:0]            idx;
	logic [AW-1:0]            idx_next;
	logic [VALUE_W-1:0]       ya;
	logic [VALUE_W-1:0]       yb;
	logic signed [VALUE_W:0]  diff;
	logic signed [FRAC_W:0]   frac_ext;
	logic signed [PROD_W-1:0] prod;
	logic [SUM_W-1:0]         sum;

	logic                     vld_s1;
	logic [FRAC_W-1:0]        frac_s1;
	logic                     vld_s2;
	logic [VALUE_W-1:0]       ya_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     out_vld_q;
	logic [VALUE_W-1:0]       out_data_q;

	assign advance  = !out_vld_q || m_tready;
	assign q_pop    = advance && !q_empty;
	assign is_write = q_entry.kind == REQ_WRITE;
	assign ram_we   = q_pop && is_write && q_entry.wr_ok;
	assign ram_re   = q_pop && !is_write;
	assign idx      = q_entry.addr[AW-1:0];
	assign idx_next = idx + AW'(1);

	// two copies of the table give both neighbor entries in the same cycle
	twl_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram_lo (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (q_entry.value),
		.re    (ram_re),
		.raddr (idx),
		.rdata (ya)
	);

	twl_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_ram_hi (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (q_entry.value),
		.re    (ram_re),
		.raddr (idx_next),
		.rdata (yb)
	);

	assign diff     = $signed({yb[VALUE_W-1], yb}) - $signed({ya[VALUE_W-1], ya});
	assign frac_ext = $signed({1'b0, frac_s1});
	assign prod     = diff * frac_ext;

	// floor shift by 16 is the upper part of the product
	assign sum = {{2{ya_s2[VALUE_W-1]}}, ya_s2} + prod_s2[PROD_W-1:FRAC_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			vld_s1    <= ram_re;
			vld_s2    <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frac_s1 <= q_entry.frac;
			ya_s2   <= ya;
			prod_s2 <= prod;
			if (table_ready) begin
				out_data_q <= sum[VALUE_W-1:0];
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/table_waveshaper_lerp_top.sv =====
// Table-lookup waveshaper with linear interpolation. A sample item (tuser low)
// maps its Q8.16 input to a phase in [0,1), scales it by table_length-1 and
// interpolates between two neighboring table entries; a table-write item
// (tuser high) stores one entry and returns nothing. The block takes one item
// per cycle unless its queue is full and gives one result per cycle unless the
// output stalls; a result passes the queue entry, RAM read, product and output
// registers in turn. A four-entry queue decouples acceptance from the lookup;
// the lookup path reads both neighbors in the same cycle from two copies of the
// table RAM, then multiplies, then adds, one register apart. The output is zero
// while table_ready is low. Reading entries that were never written gives
// undefined results. Registers change only while idle: the user must keep to it.
module table_waveshaper_lerp_top import twl_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample[23:0], table_index[33:24], table_value[49:34], zero[55:50]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// shaped[15:0]
	output logic [VALUE_W-1:0]    m_tdata
);

	logic [LENGTH_W-1:0] table_length_q;
	logic                table_ready_q;
	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	q_entry_t            q_din;
	q_entry_t            q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= LENGTH_W'(2);
			table_ready_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				CFG_TABLE_LENGTH: table_length_q <= cfg_data[LENGTH_W-1:0];
				CFG_TABLE_READY:  table_ready_q  <= cfg_data[0];
				default:          table_ready_q  <= table_ready_q;
			endcase
		end
	end

	twl_front #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_front (
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.table_length (table_length_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_entry      (q_din)
	);

	twl_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	twl_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_entry     (q_dout),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.table_ready (table_ready_q),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("queue push while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("queue pop while empty");

	a_full_after_stalled_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !q_pop) |=> q_full)
		else $error("queue lost an item while full and stalled");

endmodule
